// ===== src/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// shared types and constants of the wildcard byte pattern scanner
// ----------------------------------------------------------------------------
package wbps_pkg;

  // field and register widths fixed by the interface
  localparam int ByteW     = 8;
  localparam int OffFieldW = 32;
  localparam int PatRegW   = 64;
  localparam int MaskW     = 16;
  localparam int LenRegW   = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 64;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] CfgPatLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWildMsk = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPatLen  = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last;
  } in_beat_t;

  typedef struct packed {
    logic                 found;
    logic [OffFieldW-1:0] match_offset;
  } out_beat_t;

  // result write from the front part into the result queue
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } res_wr_t;

endpackage

// ===== src/wbps_front.sv =====
// ----------------------------------------------------------------------------
// wbps_front
// byte window, per-region byte count and parallel pattern compare; emits result beats
// ----------------------------------------------------------------------------
module wbps_front #(
  parameter int PATTERN_MAX = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [wbps_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                accept_i,
  input  wbps_pkg::in_beat_t                  in_beat_i,
  output wbps_pkg::res_wr_t                   res_wr_o
);
  import wbps_pkg::*;

  localparam int WinD = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int ExtW = (OFFSET_BITS > OffFieldW) ? OFFSET_BITS : OffFieldW + 1;

  // configuration
  logic [2*PatRegW-1:0]  pat_q;
  logic [MaskW-1:0]      wild_q;
  logic [LenRegW-1:0]    len_q;

  // scan state
  logic [ByteW-1:0]       win_q [WinD];
  logic [OFFSET_BITS-1:0] seen_q;
  logic                   done_q;

  logic [LenRegW-1:0]     len_eff;
  logic [ByteW-1:0]       age_byte [PATTERN_MAX];
  logic [LenRegW-1:0]     age;
  logic [ByteW-1:0]       sel;
  logic                   hit;
  logic                   armed;
  logic [OFFSET_BITS-1:0] len_m1;
  logic [OFFSET_BITS-1:0] off;
  logic [ExtW-1:0]        off_ext;
  logic [OffFieldW-1:0]   off_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      wild_q <= '0;
      len_q  <= LenRegW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPatLow:  pat_q[PatRegW-1:0]         <= cfg_data_i;
        CfgPatHigh: pat_q[2*PatRegW-1:PatRegW] <= cfg_data_i;
        CfgWildMsk: wild_q                     <= cfg_data_i[MaskW-1:0];
        CfgPatLen:  len_q                      <= cfg_data_i[LenRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_q == '0) begin
      len_eff = LenRegW'(1);
    end else if (len_q > LenRegW'(PATTERN_MAX)) begin
      len_eff = LenRegW'(PATTERN_MAX);
    end else begin
      len_eff = len_q;
    end
  end

  // byte by age: age 0 is the incoming byte
  always_comb begin
    age_byte[0] = in_beat_i.data_byte;
    for (int a = 1; a < PATTERN_MAX; a++) begin
      age_byte[a] = win_q[a-1];
    end
  end

  // pattern byte k lines up with the byte of age len-1-k
  always_comb begin
    hit = 1'b1;
    age = '0;
    sel = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      age = len_eff - LenRegW'(k) - LenRegW'(1);
      sel = '0;
      if (age < LenRegW'(PATTERN_MAX)) begin
        sel = age_byte[age[IdxW-1:0]];
      end
      if ((LenRegW'(k) < len_eff) && !wild_q[k] && (sel != pat_q[8*k +: 8])) begin
        hit = 1'b0;
      end
    end
  end

  assign len_m1 = OFFSET_BITS'(len_eff - LenRegW'(1));
  assign armed  = !done_q && (seen_q >= len_m1);
  assign off    = (seen_q == '1) ? '1 : seen_q - len_m1;
  assign off_ext = ExtW'(off);
  assign off_sat = (off_ext > ExtW'({OffFieldW{1'b1}})) ? '1 : off_ext[OffFieldW-1:0];

  always_comb begin
    res_wr_o = '0;
    if (accept_i) begin
      if (armed && hit) begin
        res_wr_o.valid             = 1'b1;
        res_wr_o.beat.found        = 1'b1;
        res_wr_o.beat.match_offset = off_sat;
      end else if (in_beat_i.last && !done_q) begin
        res_wr_o.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      done_q <= 1'b0;
      for (int i = 0; i < WinD; i++) begin
        win_q[i] <= '0;
      end
    end else if (accept_i) begin
      if (in_beat_i.last) begin
        seen_q <= '0;
        done_q <= 1'b0;
        for (int i = 0; i < WinD; i++) begin
          win_q[i] <= '0;
        end
      end else begin
        if (seen_q != '1) begin
          seen_q <= seen_q + OFFSET_BITS'(1);
        end
        done_q <= done_q | (armed && hit);
        if (PATTERN_MAX > 1) begin
          win_q[0] <= in_beat_i.data_byte;
          for (int i = 1; i < WinD; i++) begin
            win_q[i] <= win_q[i-1];
          end
        end
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && in_beat_i.last |=> (seen_q == '0) && !done_q)
    else $error("scan state not cleared after last byte");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr_o.valid && res_wr_o.beat.found |-> !done_q)
    else $error("second match reported in one region");

endmodule

// ===== src/wbps_queue.sv =====
// ----------------------------------------------------------------------------
// wbps_queue
// short result queue between the scanner front and the result port
// ----------------------------------------------------------------------------
module wbps_queue #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wbps_pkg::res_wr_t   res_wr_i,
  output logic                full_o,
  output logic                empty_o,
  input  logic                pop_i,
  output wbps_pkg::out_beat_t out_beat_o
);
  import wbps_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  out_beat_t       slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            wr, rd;

  assign full_o     = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign wr         = res_wr_i.valid && !full_o;
  assign rd         = pop_i && !empty_o;
  assign out_beat_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      slot_q[wr_ptr_q] <= res_wr_i.beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("result queue count beyond depth");

  a_write_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> !empty_o)
    else $error("written result beat not visible");

endmodule

// ===== src/wildcard_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// searches a byte stream for a pattern of up to 16 bytes with wildcards
// ----------------------------------------------------------------------------
// usage:
//   input channel: one byte beat per push (data_byte, last); a beat is taken
//   at a clock edge with push high and full low. last closes a region.
//   result channel: a beat (found, match_offset) sits on out_beat_o while
//   empty is low and leaves on an edge with pop high.
//   each region gives exactly one result beat: found=1 with the start offset
//   of its first match, or found=0 when the last byte arrives without one.
//   config port: the user writes pattern low/high bytes, wildcard mask and
//   pattern length with cfg_we_i only while no region is in flight (not checked).
// timing:
//   one byte per cycle while full is low; the byte window, the parallel compare of
//   all pattern positions and the offset arithmetic sit in one front stage.
//   a result beat is written to the queue with its byte and shows the cycle after.
//   when the receiver stalls, results pile up in a QUEUE_DEPTH deep queue;
//   full rises only once that queue is full, so bytes keep flowing until then.
// reset:
//   window, byte count and match flag clear, the queue empties, config goes
//   to zero pattern, no wildcards and length one.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
  parameter int PATTERN_MAX = 16,
  parameter int OFFSET_BITS = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wbps_pkg::CfgDataW-1:0] cfg_data_i,
  // byte beats in
  input  logic                          push,
  output logic                          full,
  input  wbps_pkg::in_beat_t            in_beat_i,
  // result beats out
  output logic                          empty,
  input  logic                          pop,
  output wbps_pkg::out_beat_t           out_beat_o
);
  import wbps_pkg::*;

  logic    accept;
  res_wr_t res_wr;

  // a byte beat is taken whenever the queue has room for its possible result
  assign accept = push && !full;

  wbps_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .in_beat_i  (in_beat_i),
    .res_wr_o   (res_wr)
  );

  // decouples the scanner from a stalling receiver
  wbps_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_wr_i   (res_wr),
    .full_o     (full),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_beat_o (out_beat_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the wildcard byte pattern scanner
// ----------------------------------------------------------------------------
// byte beats go in through the push/full side and verdict beats come back
// through the empty/pop side. each accepted byte is run through a local
// scan model that keeps its own window, byte count and match flag, and every
// verdict beat is checked field by field against the oldest prediction.
// directed regions cover reset config, wildcards, short regions, matches on
// the last byte and the length limits. random regions plant the pattern,
// near misses and noise under many pattern settings, with both sides stalling
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wbps_pkg::*;

  localparam int PatMax     = 16;
  localparam int ByteTarget = 1950;
  localparam int PhaseBytes = 120;
  localparam int SettleCyc  = 4;

  typedef enum int {RegionPlanted, RegionNearMiss, RegionNoise} region_kind_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                push;
  logic                full;
  in_beat_t            in_beat;
  logic                empty;
  logic                pop;
  out_beat_t           out_beat;

  // shadow of the config registers
  logic [PatRegW-1:0] pat_lo_q;
  logic [PatRegW-1:0] pat_hi_q;
  logic [MaskW-1:0]   wild_q;
  logic [LenRegW-1:0] len_q;

  // scan state of the current region
  logic [ByteW-1:0]     hist_q [PatMax-1];
  logic [OffFieldW-1:0] seen_q;
  bit                   matched_q;

  // verdicts still to come back, oldest first
  out_beat_t pending_verdicts[$];

  int  mismatches;
  int  bytes_sent;
  int  regions_sent;
  int  settings_used;
  int  hits_seen;
  int  misses_seen;
  bit  tx_idle;
  bit  rx_idle;

  wildcard_byte_pattern_scanner i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .push       (push),
    .full       (full),
    .in_beat_i  (in_beat),
    .empty      (empty),
    .pop        (pop),
    .out_beat_o (out_beat)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // scan model
  // ---------------------------------------------------------------------------

  // length register 0 acts as 1, anything past 16 acts as 16
  function automatic int active_len();
    int n;
    n = int'(len_q);
    if (n == 0) n = 1;
    if (n > PatMax) n = PatMax;
    return n;
  endfunction

  function automatic logic [ByteW-1:0] pat_byte(int k);
    logic [2*PatRegW-1:0] pat;
    pat = {pat_hi_q, pat_lo_q};
    return pat[8*k +: 8];
  endfunction

  function automatic void clear_scan();
    foreach (hist_q[i]) hist_q[i] = '0;
    seen_q    = '0;
    matched_q = 1'b0;
  endfunction

  // appends one prediction behind the ones still outstanding
  function automatic void queue_verdict(out_beat_t v);
    pending_verdicts.insert(pending_verdicts.size(), v);
  endfunction

  // one accepted byte beat: compare the window ending here, then shift it in
  function automatic void predict_scan(logic [ByteW-1:0] b, logic is_last);
    int               n;
    bit               hit;
    logic [ByteW-1:0] cb;
    out_beat_t        verdict;
    n = active_len();
    // a window only counts once the region holds n bytes, this one included
    if (!matched_q && seen_q >= OffFieldW'(n - 1)) begin
      hit = 1'b1;
      for (int k = 0; k < n; k++) begin
        // pattern byte k lines up with the byte n-1-k beats back
        cb = (k == n - 1) ? b : hist_q[n - 2 - k];
        if (!wild_q[k] && cb != pat_byte(k)) hit = 1'b0;
      end
      if (hit) begin
        verdict.found        = 1'b1;
        verdict.match_offset = (seen_q == '1) ? '1 : seen_q - OffFieldW'(n - 1);
        queue_verdict(verdict);
        matched_q = 1'b1;
      end
    end
    if (is_last) begin
      // no match in the whole region: a single miss verdict
      if (!matched_q) begin
        verdict = '0;
        queue_verdict(verdict);
      end
      clear_scan();
    end else begin
      for (int i = PatMax - 2; i > 0; i--) hist_q[i] = hist_q[i - 1];
      hist_q[0] = b;
      if (seen_q != '1) seen_q = seen_q + OffFieldW'(1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // drivers, all called and returning at a falling edge
  // ---------------------------------------------------------------------------

  // writes all four registers back to back, we held high throughout
  task automatic load_pattern(input logic [CfgDataW-1:0] lo, input logic [CfgDataW-1:0] hi,
                              input logic [CfgDataW-1:0] mask_word,
                              input logic [CfgDataW-1:0] len_word);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgPatLow;
    cfg_data <= lo;
    pat_lo_q = lo;
    @(negedge clk_i);
    cfg_idx  <= CfgPatHigh;
    cfg_data <= hi;
    pat_hi_q = hi;
    @(negedge clk_i);
    cfg_idx  <= CfgWildMsk;
    cfg_data <= mask_word;
    wild_q = mask_word[MaskW-1:0];
    @(negedge clk_i);
    cfg_idx  <= CfgPatLen;
    cfg_data <= len_word;
    len_q = len_word[LenRegW-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // one byte beat, after a random gap when the sender is allowed to idle
  task automatic send_byte(input logic [ByteW-1:0] b, input logic is_last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push    <= 1'b1;
    in_beat <= in_beat_t'{data_byte: b, last: is_last};
    do @(posedge clk_i); while (full);
    predict_scan(b, is_last);
    bytes_sent++;
    if (is_last) regions_sent++;
    @(negedge clk_i);
  endtask

  // stop sending until every verdict is back, then let the front stage empty
  task automatic settle();
    push <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  // half the filler bytes come from the pattern itself to provoke overlaps
  function automatic logic [ByteW-1:0] filler_byte();
    if ($urandom_range(0, 1)) return ByteW'($urandom);
    return pat_byte($urandom_range(0, active_len() - 1));
  endfunction

  task automatic send_region(input region_kind_e kind);
    logic [ByteW-1:0] seq[$];
    int               n;
    int               pre;
    int               post;
    int               flip;
    n = active_len();
    if (kind == RegionNoise) begin
      repeat ($urandom_range(1, 24)) seq.insert(seq.size(), filler_byte());
    end else begin
      pre  = $urandom_range(0, 12);
      post = $urandom_range(0, 6);
      repeat (pre) seq.insert(seq.size(), filler_byte());
      for (int k = 0; k < n; k++) begin
        seq.insert(seq.size(), wild_q[k] ? ByteW'($urandom) : pat_byte(k));
      end
      if (kind == RegionNearMiss) begin
        flip = $urandom_range(0, n - 1);
        seq[pre + flip] = seq[pre + flip] ^ ByteW'($urandom_range(1, 255));
      end
      // post of zero puts the match end on the last byte
      repeat (post) seq.insert(seq.size(), filler_byte());
    end
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset config: single zero byte pattern
  task automatic test_reset_config();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_byte(8'h12, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    settle();
  endtask

  // "A?C" with garbage in unused pattern bytes and unused wildcard bits;
  // bytes after the match and the closing beat give nothing
  task automatic test_wildcard_gap();
    load_pattern(64'h5A5A_5A5A_5A43_EE41, '1, 64'h0000_0000_0000_FFF2, 64'd3);
    send_byte(8'h41, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h5A, 1'b1);
    settle();
  endtask

  // "??C": a one byte region must not match against the cleared window,
  // then the window that ends at the last byte matches
  task automatic test_short_region();
    load_pattern(64'h0000_0000_0043_0000, '0, 64'h0000_0000_0000_0003, 64'd3);
    send_byte(8'h43, 1'b1);
    send_byte(8'h78, 1'b0);
    send_byte(8'h79, 1'b0);
    send_byte(8'h43, 1'b1);
    settle();
  endtask

  // length zero acts as one, length 31 acts as sixteen
  task automatic test_length_limits();
    load_pattern(64'h0000_0000_0000_00AB, '0, '0, 64'd0);
    send_byte(8'hAB, 1'b1);
    settle();
    load_pattern({$urandom, $urandom}, {$urandom, $urandom}, 64'h0000_0000_0000_FFFF,
                 64'd31);
    for (int i = 0; i < PatMax; i++) send_byte((i % 2) ? 8'hFF : 8'h00, i == PatMax - 1);
    settle();
  endtask

  // random settings, each phase a run of regions; extremes come first
  task automatic test_random_regions();
    int                  phase;
    int                  phase_start;
    int                  pick;
    logic [CfgDataW-1:0] mask_word;
    logic [CfgDataW-1:0] len_word;
    phase = 0;
    while (bytes_sent < ByteTarget) begin
      mask_word = {$urandom, $urandom};
      len_word  = {$urandom, $urandom};
      mask_word[MaskW-1:0]   = (phase % 3 == 0) ? '0 : MaskW'($urandom & $urandom);
      len_word[LenRegW-1:0]  = LenRegW'($urandom_range(0, 31));
      case (phase)
        0: begin
          mask_word = '0;
          len_word  = 64'd16;
        end
        1: len_word = 64'd1;
        2: len_word[LenRegW-1:0] = 5'd31;
        3: len_word[LenRegW-1:0] = 5'd0;
        4: mask_word = '1;
        default: ;
      endcase
      load_pattern({$urandom, $urandom}, {$urandom, $urandom}, mask_word, len_word);
      // every fourth phase runs both sides flat out
      tx_idle = (phase % 4 != 1) && ($urandom_range(0, 3) != 0);
      rx_idle = (phase % 4 != 1) && ($urandom_range(0, 3) != 0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes && bytes_sent < ByteTarget) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) send_region(RegionPlanted);
        else if (pick < 8) send_region(RegionNearMiss);
        else send_region(RegionNoise);
        // now and then hold the sender until all verdicts are back
        if ($urandom_range(0, 19) == 0) settle();
      end
      settle();
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // verdict side: random pop stalls, each accepted beat checked in order
  // ---------------------------------------------------------------------------
  initial begin
    int        stall;
    out_beat_t got;
    out_beat_t want;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got = out_beat;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected verdict beat: found %0d match_offset %0d", got.found,
               got.match_offset);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (want.found) hits_seen++;
        else misses_seen++;
        if (got.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, got.found);
          mismatches++;
        end
        if (got.match_offset !== want.match_offset) begin
          $error("match_offset: expected %0d, actual %0d", want.match_offset,
                 got.match_offset);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = CfgPatLow;
    cfg_data = '0;
    push     = 1'b0;
    in_beat  = '0;
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    // shadow starts at the reset config
    pat_lo_q = '0;
    pat_hi_q = '0;
    wild_q   = '0;
    len_q    = 5'd1;
    clear_scan();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_config();
    test_wildcard_gap();
    test_short_region();
    test_length_limits();
    test_random_regions();
    settle();

    $display("scanned %0d bytes in %0d regions under %0d pattern settings", bytes_sent,
             regions_sent, settings_used);
    $display("checked %0d match and %0d no-match verdicts", hits_seen, misses_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wbps_pkg.sv
src/wbps_front.sv
src/wbps_queue.sv
src/wildcard_byte_pattern_scanner.sv
tb/sv/tb.sv
